@@ sv/hamming_product_block_decoder_assert.svh @@
// Assertion macros for the product block decoder
`ifndef HAMMING_PRODUCT_BLOCK_DECODER_ASSERT_SVH
`define HAMMING_PRODUCT_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication
`define HPBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hpbd_pkg.sv @@
`default_nettype none

package hpbd_pkg;

  localparam int unsigned COLS      = 8;
  localparam int unsigned ROWS      = 5;
  localparam int unsigned DATA_ROWS = 4;
  localparam int unsigned DATA_COLS = 4;
  localparam int unsigned BLOCK_W   = COLS * ROWS;
  localparam int unsigned DATA_W    = DATA_COLS * DATA_ROWS;
  localparam int unsigned SYN_W     = 3;
  localparam int unsigned COUNT_W   = 3;

  typedef logic [COLS-1:0] row_t;

  // single-bit flip mask, indexed by {s2, s1, s0}
  localparam row_t SYN_FLIP [2**SYN_W] = '{
    8'h00, 8'h40, 8'h20, 8'h04, 8'h10, 8'h02, 8'h01, 8'h08
  };

  typedef struct packed {
    logic [BLOCK_W-1:0] corrected_block;
    logic [DATA_W-1:0]  decoded_data;
    row_t               column_syndrome;
    logic [COUNT_W-1:0] flagged_rows;
  } result_t;

  function automatic logic [SYN_W-1:0] row_syndrome(input row_t m);
    logic s2, s1, s0;
    s2 = m[0] ^ m[1] ^ m[3] ^ m[4];
    s1 = m[0] ^ m[2] ^ m[3] ^ m[5];
    s0 = m[1] ^ m[2] ^ m[3] ^ m[6];
    return {s2, s1, s0};
  endfunction

endpackage

`default_nettype wire

@@ sv/hamming_product_block_decoder.sv @@
// Throughput: one block per cycle unless a low result_ready holds the output stalled.
// Path: input register, decode logic, result register.
// Ready propagates combinationally back through both register stages.
// Reset (rst, synchronous, active high) empties both stages; data registers are not reset.
`default_nettype none

module hamming_product_block_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             block_valid,
  output logic                                  block_ready,
  input  wire logic [hpbd_pkg::BLOCK_W-1:0]     received_block,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [hpbd_pkg::BLOCK_W-1:0]          corrected_block,
  output logic [hpbd_pkg::DATA_W-1:0]           decoded_data,
  output logic [hpbd_pkg::COLS-1:0]             column_syndrome,
  output logic [hpbd_pkg::COUNT_W-1:0]          flagged_rows
);

`include "hamming_product_block_decoder_assert.svh"

  logic                          stage_valid;
  logic [hpbd_pkg::BLOCK_W-1:0]  stage_block;
  hpbd_pkg::result_t             decoded;
  hpbd_pkg::result_t             result;
  logic                          result_load;

  assign result_load = !result_valid || result_ready;
  assign block_ready = !stage_valid || result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (block_ready) begin
      stage_valid <= block_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (block_valid && block_ready) begin
      stage_block <= received_block;
    end
  end

  hpbd_decode u_decode (
    .block  (stage_block),
    .result (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && result_load) begin
      result <= decoded;
    end
  end

  assign corrected_block = result.corrected_block;
  assign decoded_data    = result.decoded_data;
  assign column_syndrome = result.column_syndrome;
  assign flagged_rows    = result.flagged_rows;

  `HPBD_ASSERT_NEXT(a_stage_hold, clk, rst, stage_valid && !result_load, stage_valid && $stable(stage_block), "stalled input stage lost or changed its block")
  `HPBD_ASSERT_NEXT(a_stage_moves, clk, rst, stage_valid && result_load, result_valid, "block left the input stage without reaching the result register")
  `HPBD_ASSERT_NOW(a_count_range, clk, rst, result_valid, flagged_rows <= 3'd5, "flagged row count out of range")
  `HPBD_ASSERT_NOW(a_data_match, clk, rst, result_valid, decoded_data == {corrected_block[27:24], corrected_block[19:16], corrected_block[11:8], corrected_block[3:0]}, "decoded data disagrees with corrected block")

endmodule

`default_nettype wire

@@ sv/hpbd_decode.sv @@
`default_nettype none

module hpbd_decode (
  input  wire logic [hpbd_pkg::BLOCK_W-1:0] block,
  output hpbd_pkg::result_t                 result
);

  hpbd_pkg::row_t                     rows     [hpbd_pkg::ROWS];
  logic [hpbd_pkg::SYN_W-1:0]         syn      [hpbd_pkg::ROWS];
  logic                               par      [hpbd_pkg::ROWS];
  hpbd_pkg::row_t                     colsyn;
  logic [hpbd_pkg::COUNT_W-1:0]       count;
  hpbd_pkg::row_t                     fixed    [hpbd_pkg::DATA_ROWS];

  always_comb begin
    colsyn = '0;
    count  = '0;
    for (int r = 0; r < hpbd_pkg::ROWS; r++) begin
      rows[r] = block[r*hpbd_pkg::COLS +: hpbd_pkg::COLS];
      syn[r]  = hpbd_pkg::row_syndrome(rows[r]);
      par[r]  = ^rows[r];
      colsyn  = colsyn ^ rows[r];
      count   = count + hpbd_pkg::COUNT_W'(syn[r] != '0 || par[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < hpbd_pkg::DATA_ROWS; r++) begin
      if (syn[r] != '0) begin
        if (count == hpbd_pkg::COUNT_W'(1) || !par[r]) begin
          fixed[r] = rows[r] ^ colsyn;
        end else begin
          fixed[r] = rows[r] ^ hpbd_pkg::SYN_FLIP[syn[r]];
        end
      end else if (par[r]) begin
        fixed[r] = rows[r] ^ colsyn;
      end else begin
        fixed[r] = rows[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < hpbd_pkg::DATA_ROWS; r++) begin
      result.corrected_block[r*hpbd_pkg::COLS +: hpbd_pkg::COLS] = fixed[r];
      result.decoded_data[r*hpbd_pkg::DATA_COLS +: hpbd_pkg::DATA_COLS] =
        fixed[r][hpbd_pkg::DATA_COLS-1:0];
    end
    // parity row passes through
    result.corrected_block[hpbd_pkg::DATA_ROWS*hpbd_pkg::COLS +: hpbd_pkg::COLS] =
      rows[hpbd_pkg::DATA_ROWS];
    result.column_syndrome = colsyn;
    result.flagged_rows    = count;
  end

endmodule

`default_nettype wire

@@ dv/hamming_product_block_decoder_tb.sv @@
`timescale 1ns / 100ps

module hamming_product_block_decoder_tb;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned QUIET_FIRST  = 200;
  localparam int unsigned QUIET_LAST   = 330;
  localparam int unsigned IDX_W        = $clog2(hpbd_pkg::BLOCK_W);

  class decode_scoreboard;
    hpbd_pkg::result_t pending_decodes[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       rows_changed;

    function new();
      errors       = 0;
      checked      = 0;
      rows_changed = 0;
    endfunction

    function hpbd_pkg::result_t predict_decode(logic [hpbd_pkg::BLOCK_W-1:0] blk);
      hpbd_pkg::row_t             rows[hpbd_pkg::ROWS];
      logic [hpbd_pkg::SYN_W-1:0] syn[hpbd_pkg::ROWS];
      logic                       par[hpbd_pkg::ROWS];
      hpbd_pkg::row_t             colsyn;
      hpbd_pkg::row_t             m;
      hpbd_pkg::row_t             flip;
      int unsigned                flagged;
      hpbd_pkg::result_t          res;
      colsyn  = '0;
      flagged = 0;
      for (int r = 0; r < hpbd_pkg::ROWS; r++) begin
        rows[r] = blk[8*r +: 8];
        // {s2, s1, s0}
        syn[r]  = {^(rows[r] & 8'h1B), ^(rows[r] & 8'h2D), ^(rows[r] & 8'h4E)};
        par[r]  = ^rows[r];
        colsyn ^= rows[r];
        if (syn[r] != 3'b000 || par[r]) flagged++;
      end
      for (int r = 0; r < hpbd_pkg::DATA_ROWS; r++) begin
        m = rows[r];
        if (flagged == 1 && syn[r] != 3'b000) begin
          m ^= colsyn;
        end else if (par[r] && syn[r] == 3'b000) begin
          m ^= colsyn;
        end else if (syn[r] != 3'b000) begin
          if (!par[r]) begin
            m ^= colsyn;
          end else begin
            case (syn[r])
              3'b100:  flip = 8'h10;
              3'b010:  flip = 8'h20;
              3'b001:  flip = 8'h40;
              3'b011:  flip = 8'h04;
              3'b101:  flip = 8'h02;
              3'b110:  flip = 8'h01;
              default: flip = 8'h08;
            endcase
            m ^= flip;
          end
        end
        rows[r] = m;
      end
      res.corrected_block = {rows[4], rows[3], rows[2], rows[1], rows[0]};
      res.decoded_data    = {rows[3][3:0], rows[2][3:0], rows[1][3:0], rows[0][3:0]};
      res.column_syndrome = colsyn;
      res.flagged_rows    = flagged[hpbd_pkg::COUNT_W-1:0];
      return res;
    endfunction

    function void note_block(logic [hpbd_pkg::BLOCK_W-1:0] blk);
      hpbd_pkg::result_t res;
      res = predict_decode(blk);
      if (res.corrected_block != blk) rows_changed++;
      pending_decodes.push_back(res);
    endfunction

    function void check_result(logic [hpbd_pkg::BLOCK_W-1:0] cb,
                               logic [hpbd_pkg::DATA_W-1:0] dd, hpbd_pkg::row_t cs,
                               logic [hpbd_pkg::COUNT_W-1:0] fr);
      hpbd_pkg::result_t exp_res;
      if (pending_decodes.size() == 0) begin
        $error("result transfer with no block outstanding: corrected_block %h", cb);
        errors++;
        return;
      end
      exp_res = pending_decodes.pop_front();
      checked++;
      if (cb !== exp_res.corrected_block) begin
        $error("corrected_block: expected %h, got %h", exp_res.corrected_block, cb);
        errors++;
      end
      if (dd !== exp_res.decoded_data) begin
        $error("decoded_data: expected %h, got %h", exp_res.decoded_data, dd);
        errors++;
      end
      if (cs !== exp_res.column_syndrome) begin
        $error("column_syndrome: expected %h, got %h", exp_res.column_syndrome, cs);
        errors++;
      end
      if (fr !== exp_res.flagged_rows) begin
        $error("flagged_rows: expected %0d, got %0d", exp_res.flagged_rows, fr);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_decodes.size();
    endfunction
  endclass

  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           block_valid    = 1'b0;
  logic                           block_ready;
  logic [hpbd_pkg::BLOCK_W-1:0]   received_block = '0;
  logic                           result_valid;
  logic                           result_ready   = 1'b0;
  logic [hpbd_pkg::BLOCK_W-1:0]   corrected_block;
  logic [hpbd_pkg::DATA_W-1:0]    decoded_data;
  logic [hpbd_pkg::COLS-1:0]      column_syndrome;
  logic [hpbd_pkg::COUNT_W-1:0]   flagged_rows;

  logic                 quiet = 1'b0;
  int unsigned          stall_cycles = 0;
  int unsigned          n_directed = 0;
  int unsigned          n_random = 0;
  int unsigned          n_raw = 0;

  decode_scoreboard sb = new();

  hamming_product_block_decoder dut (
    .clk             (clk),
    .rst             (rst),
    .block_valid     (block_valid),
    .block_ready     (block_ready),
    .received_block  (received_block),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .corrected_block (corrected_block),
    .decoded_data    (decoded_data),
    .column_syndrome (column_syndrome),
    .flagged_rows    (flagged_rows)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (block_valid && block_ready) sb.note_block(received_block);
      if (result_valid && result_ready)
        sb.check_result(corrected_block, decoded_data, column_syndrome, flagged_rows);
      if ((block_valid && block_ready) || (result_valid && result_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [hpbd_pkg::BLOCK_W-1:0] encode_block(
    logic [hpbd_pkg::DATA_W-1:0] d
  );
    hpbd_pkg::row_t               w;
    hpbd_pkg::row_t               colpar;
    logic [hpbd_pkg::BLOCK_W-1:0] b;
    b      = '0;
    colpar = '0;
    for (int r = 0; r < hpbd_pkg::DATA_ROWS; r++) begin
      w[3:0] = d[4*r +: 4];
      w[4]   = w[0] ^ w[1] ^ w[3];
      w[5]   = w[0] ^ w[2] ^ w[3];
      w[6]   = w[1] ^ w[2] ^ w[3];
      w[7]   = ^w[6:0];
      b[8*r +: 8] = w;
      colpar ^= w;
    end
    b[8*hpbd_pkg::DATA_ROWS +: 8] = colpar;
    return b;
  endfunction

  // entered and left at a falling edge
  task automatic send_block(logic [hpbd_pkg::BLOCK_W-1:0] blk);
    while (!quiet && $urandom_range(99) < 11) begin
      block_valid <= 1'b0;
      @(negedge clk);
    end
    block_valid    <= 1'b1;
    received_block <= blk;
    do @(posedge clk); while (!block_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [hpbd_pkg::BLOCK_W-1:0] blk;
    logic [hpbd_pkg::BLOCK_W-1:0] directed[$];
    logic [hpbd_pkg::BLOCK_W-1:0] cw;
    logic [IDX_W-1:0]             idx;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    cw = encode_block(16'hA5C3);
    directed.push_back('0);
    directed.push_back({hpbd_pkg::BLOCK_W{1'b1}});
    directed.push_back(encode_block(16'hFFFF));
    directed.push_back(cw);
    directed.push_back(cw ^ (40'd1 << 0));
    directed.push_back(cw ^ (40'd1 << 11));
    directed.push_back(cw ^ (40'd1 << 22));
    directed.push_back(cw ^ (40'd1 << 31));
    directed.push_back(cw ^ (40'd1 << 7));           // parity column only
    directed.push_back(cw ^ (40'd1 << 36));          // column-parity row alone
    directed.push_back(cw ^ (40'd1 << 36) ^ (40'd1 << 2));
    directed.push_back(cw ^ (40'd3 << 8));           // two errors, one row
    directed.push_back(cw ^ (40'd1 << 3) ^ (40'd1 << 19));
    directed.push_back(cw ^ 40'h01_01_01_01_01);     // every row flagged
    directed.push_back(cw ^ 40'h80_00_00_00_80);
    directed.push_back(40'h55_55_55_55_55);
    directed.push_back(40'hAA_AA_AA_AA_AA);
    directed.push_back(40'd1 << 39);
    directed.push_back(40'd1);
    directed.push_back(encode_block(16'h0001) ^ (40'd1 << 5));
    directed.push_back(encode_block(16'h8000) ^ (40'd1 << 30) ^ (40'd1 << 31));

    foreach (directed[i]) begin
      send_block(directed[i]);
      n_directed++;
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
      if ($urandom_range(99) < 30) begin
        blk = {8'($urandom_range(255)), $urandom()};
        n_raw++;
      end else begin
        blk = encode_block(16'($urandom_range(65535)));
        repeat ($urandom_range(3)) begin
          idx = IDX_W'($urandom_range(hpbd_pkg::BLOCK_W-1));
          blk[idx] = ~blk[idx];
        end
      end
      send_block(blk);
      n_random++;
    end
    quiet = 1'b0;
    block_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d blocks: %0d directed, %0d random (%0d raw, rest with 0-3 flips)",
             n_directed + n_random, n_directed, n_random, n_raw);
    $display("Checked %0d results, %0d of them with a row corrected", sb.checked,
             sb.rows_changed);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/hpbd_pkg.sv
sv/hpbd_decode.sv
sv/hamming_product_block_decoder.sv
dv/hamming_product_block_decoder_tb.sv
